// ===== design/lrc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrc_pkg: shared definitions of the log record checker
// Event codes, the queue entry type and the byte-wise CRC-32 step.
// ----------------------------------------------------------------------------
package lrc_pkg;

   localparam logic [2:0] EV_OK    = 3'd0;
   localparam logic [2:0] EV_MAGIC = 3'd1;
   localparam logic [2:0] EV_CRC   = 3'd2;
   localparam logic [2:0] EV_TRUNC = 3'd3;
   localparam logic [2:0] EV_END   = 3'd4;

   localparam logic [31:0] CrcPoly = 32'hEDB88320;
   localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

   // Queue between the parser and the result sequencer.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // One queue entry holds every result caused by one input byte: an optional
   // first result and an optional end-of-log result. Both share the record
   // count; the end-of-log result always reports a zero header.
   typedef struct packed {
      logic        first_valid;
      logic [2:0]  first_kind;
      logic        end_valid;
      logic [7:0]  op_code;
      logic [31:0] table_name_length;
      logic [63:0] row_id;
      logic [31:0] payload_length;
      logic [31:0] entries_accepted;
   } lrc_event_type;

   // Reflected CRC-32 update by one byte, one polynomial step per bit.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'b0, data};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CrcPoly : 32'h0);
      end
      return c;
   endfunction

endpackage

// ===== design/lrc_front.sv =====
// ----------------------------------------------------------------------------
// lrc_front: record parser
// Accepts one log byte per cycle while accept is high, tracks the record
// fields and the running CRC, and posts a byte's results as one queue entry.
// ----------------------------------------------------------------------------
module lrc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [31:0]            csr_write_data,
   input  logic                   accept,
   input  logic [7:0]             log_byte,
   input  logic                   end_of_log,
   output logic                   push,
   output lrc_pkg::lrc_event_type push_data
);

   localparam logic [2:0] PH_MAGIC = 3'd0;
   localparam logic [2:0] PH_OP    = 3'd1;
   localparam logic [2:0] PH_NLEN  = 3'd2;
   localparam logic [2:0] PH_NAME  = 3'd3;
   localparam logic [2:0] PH_ROW   = 3'd4;
   localparam logic [2:0] PH_PLEN  = 3'd5;
   localparam logic [2:0] PH_PAY   = 3'd6;
   localparam logic [2:0] PH_CRC   = 3'd7;

   logic [31:0] magic_ff;
   logic [2:0]  phase_ff,   phase_in;
   logic [31:0] count_ff,   count_in;
   logic [63:0] shift_ff,   shift_in;
   logic [7:0]  op_ff,      op_in;
   logic [31:0] nlen_ff,    nlen_in;
   logic [63:0] row_ff,     row_in;
   logic [31:0] plen_ff,    plen_in;
   logic [31:0] crc_ff,     crc_in;
   logic [31:0] records_ff, records_in;
   logic        halted_ff,  halted_in;

   logic [63:0] shifted;
   logic [31:0] count_inc;
   logic        first_valid;
   logic [2:0]  first_kind;
   logic        first_header;
   logic        end_valid;

   assign shifted   = shift_ff | ({56'b0, log_byte} << {count_ff[2:0], 3'b000});
   assign count_inc = count_ff + 32'd1;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      shift_in     = shift_ff;
      op_in        = op_ff;
      nlen_in      = nlen_ff;
      row_in       = row_ff;
      plen_in      = plen_ff;
      crc_in       = crc_ff;
      records_in   = records_ff;
      halted_in    = halted_ff;
      first_valid  = 1'b0;
      first_kind   = lrc_pkg::EV_OK;
      first_header = 1'b0;
      end_valid    = 1'b0;

      if (accept && !halted_ff) begin
         if (phase_ff != PH_CRC) begin
            crc_in = lrc_pkg::crc_byte(crc_ff, log_byte);
         end
         unique case (phase_ff)
            PH_MAGIC: begin
               shift_in = shifted;
               count_in = count_inc;
               if (count_inc == 32'd4) begin
                  if (shifted[31:0] != magic_ff) begin
                     first_valid = 1'b1;
                     first_kind  = lrc_pkg::EV_MAGIC;
                     halted_in   = 1'b1;
                  end else begin
                     op_in    = '0;
                     nlen_in  = '0;
                     row_in   = '0;
                     plen_in  = '0;
                     phase_in = PH_OP;
                     count_in = '0;
                     shift_in = '0;
                  end
               end
            end
            PH_OP: begin
               op_in    = log_byte;
               phase_in = PH_NLEN;
               count_in = '0;
               shift_in = '0;
            end
            PH_NLEN: begin
               shift_in = shifted;
               count_in = count_inc;
               if (count_inc == 32'd4) begin
                  nlen_in  = shifted[31:0];
                  phase_in = (shifted[31:0] != 32'd0) ? PH_NAME : PH_ROW;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_NAME: begin
               count_in = count_inc;
               if (count_inc == nlen_ff) begin
                  phase_in = PH_ROW;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_ROW: begin
               shift_in = shifted;
               count_in = count_inc;
               if (count_inc == 32'd8) begin
                  row_in   = shifted;
                  phase_in = PH_PLEN;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_PLEN: begin
               shift_in = shifted;
               count_in = count_inc;
               if (count_inc == 32'd4) begin
                  plen_in  = shifted[31:0];
                  phase_in = (shifted[31:0] != 32'd0) ? PH_PAY : PH_CRC;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_PAY: begin
               count_in = count_inc;
               if (count_inc == plen_ff) begin
                  phase_in = PH_CRC;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_CRC: begin
               shift_in = shifted;
               count_in = count_inc;
               if (count_inc == 32'd4) begin
                  first_valid  = 1'b1;
                  first_header = 1'b1;
                  if (shifted[31:0] == ~crc_ff) begin
                     first_kind = lrc_pkg::EV_OK;
                     if (records_ff != 32'hFFFFFFFF) begin
                        records_in = records_ff + 32'd1;
                     end
                     crc_in   = lrc_pkg::CrcOnes;
                     phase_in = PH_MAGIC;
                     count_in = '0;
                     shift_in = '0;
                  end else begin
                     first_kind = lrc_pkg::EV_CRC;
                     halted_in  = 1'b1;
                  end
               end
            end
         endcase
      end

      // A record left unfinished at end of log is reported as truncated,
      // with the header only once the magic word has been passed.
      if (accept && end_of_log) begin
         end_valid = 1'b1;
         if (!halted_in && !(phase_in == PH_MAGIC && count_in == 32'd0)) begin
            first_valid  = 1'b1;
            first_kind   = lrc_pkg::EV_TRUNC;
            first_header = (phase_in != PH_MAGIC);
         end
      end
   end

   always_comb begin
      push_data.first_valid       = first_valid;
      push_data.first_kind        = first_kind;
      push_data.end_valid         = end_valid;
      push_data.op_code           = first_header ? op_in   : 8'd0;
      push_data.table_name_length = first_header ? nlen_in : 32'd0;
      push_data.row_id            = first_header ? row_in  : 64'd0;
      push_data.payload_length    = first_header ? plen_in : 32'd0;
      push_data.entries_accepted  = records_in;
   end

   assign push = first_valid || end_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
      end else if (csr_write_enable) begin
         magic_ff <= csr_write_data;
      end
   end

   // End of log starts a fresh log with the parser back at its reset state.
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_log)) begin
         phase_ff   <= PH_MAGIC;
         count_ff   <= '0;
         shift_ff   <= '0;
         op_ff      <= '0;
         nlen_ff    <= '0;
         row_ff     <= '0;
         plen_ff    <= '0;
         crc_ff     <= lrc_pkg::CrcOnes;
         records_ff <= '0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         shift_ff   <= shift_in;
         op_ff      <= op_in;
         nlen_ff    <= nlen_in;
         row_ff     <= row_in;
         plen_ff    <= plen_in;
         crc_ff     <= crc_in;
         records_ff <= records_in;
         halted_ff  <= halted_in;
      end
   end

endmodule

// ===== design/lrc_queue.sv =====
// ----------------------------------------------------------------------------
// lrc_queue: event queue
// Short first-in first-out queue that decouples the parser from the result
// sequencer.
// ----------------------------------------------------------------------------
module lrc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lrc_pkg::lrc_event_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output lrc_pkg::lrc_event_type head_data
);

   lrc_pkg::lrc_event_type entry_ff [lrc_pkg::QueueDepth];

   logic [lrc_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lrc_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lrc_pkg::QueuePtrW:0]   fill_ff,   fill_in;
   logic                          do_push;
   logic                          do_pop;

   assign full       = (fill_ff == (lrc_pkg::QueuePtrW+1)'(lrc_pkg::QueueDepth));
   assign head_valid = (fill_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== design/lrc_back.sv =====
// ----------------------------------------------------------------------------
// lrc_back: result sequencer
// Turns each queue entry into one or two result beats and holds the current
// beat in an output register until it is taken.
// ----------------------------------------------------------------------------
module lrc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  lrc_pkg::lrc_event_type head_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [2:0]             rsp_event_kind,
   output logic [7:0]             rsp_op_code,
   output logic [31:0]            rsp_table_name_length,
   output logic [63:0]            rsp_row_id,
   output logic [31:0]            rsp_payload_length,
   output logic [31:0]            rsp_entries_accepted,
   output logic                   rsp_last_of_run
);

   logic        valid_ff;
   logic        second_ff, second_in;
   logic [2:0]  kind_ff,   kind_in;
   logic [7:0]  op_ff,     op_in;
   logic [31:0] nlen_ff,   nlen_in;
   logic [63:0] row_ff,    row_in;
   logic [31:0] plen_ff,   plen_in;
   logic [31:0] count_ff;
   logic        last_ff,   last_in;
   logic        load;
   logic        send_first;

   assign load       = head_valid && (!valid_ff || !rsp_stall);
   // The first result goes out unless it has already been sent.
   assign send_first = head_data.first_valid && !second_ff;

   always_comb begin
      if (send_first) begin
         kind_in   = head_data.first_kind;
         op_in     = head_data.op_code;
         nlen_in   = head_data.table_name_length;
         row_in    = head_data.row_id;
         plen_in   = head_data.payload_length;
         last_in   = !head_data.end_valid;
         second_in = head_data.end_valid;
      end else begin
         kind_in   = lrc_pkg::EV_END;
         op_in     = '0;
         nlen_in   = '0;
         row_in    = '0;
         plen_in   = '0;
         last_in   = 1'b1;
         second_in = 1'b0;
      end
   end

   assign pop = load && !second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff  <= 1'b1;
            second_ff <= second_in;
         end else if (!rsp_stall) begin
            valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= kind_in;
         op_ff    <= op_in;
         nlen_ff  <= nlen_in;
         row_ff   <= row_in;
         plen_ff  <= plen_in;
         count_ff <= head_data.entries_accepted;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_event_kind        = kind_ff;
   assign rsp_op_code           = op_ff;
   assign rsp_table_name_length = nlen_ff;
   assign rsp_row_id            = row_ff;
   assign rsp_payload_length    = plen_ff;
   assign rsp_entries_accepted  = count_ff;
   assign rsp_last_of_run       = last_ff;

endmodule

// ===== design/log_record_checker_crc32_core.sv =====
// ----------------------------------------------------------------------------
// log_record_checker_crc32_core: log record checker with CRC-32
// The first result beat of a byte passes the event queue between parser and
// sequencer, then the sequencer's output register. Throughput is one byte per
// cycle while the queue is not full. The result port moves one beat per cycle
// unless stalled; the four-entry queue absorbs bytes that cause two beats.
// Synchronous reset clears the parser, the record count and the queue, and
// sets the magic register to zero.
// ----------------------------------------------------------------------------
module log_record_checker_crc32_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_log_byte,
   input  logic        req_end_of_log,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_op_code,
   output logic [31:0] rsp_table_name_length,
   output logic [63:0] rsp_row_id,
   output logic [31:0] rsp_payload_length,
   output logic [31:0] rsp_entries_accepted,
   output logic        rsp_last_of_run
);

   logic                   accept;
   logic                   push;
   lrc_pkg::lrc_event_type push_data;
   logic                   full;
   logic                   pop;
   logic                   head_valid;
   lrc_pkg::lrc_event_type head_data;

   // Stall comes from the registered queue fill alone.
   assign req_stall = full;
   assign accept    = req_valid && !full;

   lrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .log_byte         (req_log_byte),
      .end_of_log       (req_end_of_log),
      .push             (push),
      .push_data        (push_data)
   );

   lrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   lrc_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (head_valid),
      .head_data             (head_data),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_event_kind        (rsp_event_kind),
      .rsp_op_code           (rsp_op_code),
      .rsp_table_name_length (rsp_table_name_length),
      .rsp_row_id            (rsp_row_id),
      .rsp_payload_length    (rsp_payload_length),
      .rsp_entries_accepted  (rsp_entries_accepted),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule
